// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the mesh vertex normal averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mnva_pkg.sv =====
// Shared constants, types and functions of the mesh vertex normal averager.
package mnva_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VI_W         = 10;
  localparam int MAX_CORNERS  = 4;
  localparam int CORNER_LIM   = (MAX_CORNERS < 4) ? MAX_CORNERS : 4;
  localparam int MAX_SHARED   = 255;
  localparam int CNT_W        = 8;
  localparam int POS_W        = 32;
  localparam int SUM_W        = 40;
  localparam int NRM_W        = 32;
  localparam int EMAG_W       = 30;
  localparam int PROD_W       = 60;
  localparam int CM_W         = 62;
  localparam int MUL_W        = 32;
  localparam int DVD_W        = 64;
  localparam int DSR_W        = 32;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int OP_W         = 2;
  localparam int CC_W         = 3;
  localparam int FRAC_W       = 30;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_EDGE,
    ST_MUL_GO, ST_MUL_WT, ST_CROSS, ST_NORM, ST_SQ_GO, ST_SQ_WT,
    ST_SQRT_GO, ST_SQRT_WT, ST_DIV_GO, ST_DIV_WT, ST_ACC_RD, ST_ACC_WR,
    ST_VR_RD, ST_VR_CHK, ST_OUT
  } state_t;

  function automatic logic [2:0] pair_a(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0: r = 3'd1;
      3'd1: r = 3'd2;
      3'd2: r = 3'd2;
      3'd3: r = 3'd0;
      3'd4: r = 3'd0;
      3'd5: r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_b(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0: r = 3'd5;
      3'd1: r = 3'd4;
      3'd2: r = 3'd3;
      3'd3: r = 3'd5;
      3'd4: r = 3'd4;
      3'd5: r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mnva_mul.sv =====
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
module mnva_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mnva_pkg::MUL_W-1:0]     a,
  input  logic [mnva_pkg::MUL_W-1:0]     b,
  output logic                           done,
  output logic [2*mnva_pkg::MUL_W-1:0]   product
);
  import mnva_pkg::*;

  logic [2*MUL_W-1:0]       acc_r, mcand_r;
  logic [MUL_W-1:0]         mplier_r;
  logic [$clog2(MUL_W)-1:0] cnt_r;
  logic                     run_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(MUL_W)'(MUL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= {{MUL_W{1'b0}}, a};
      mplier_r <= b;
    end else if (run_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/core/mnva_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module mnva_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mnva_pkg::DVD_W-1:0]  dividend,
  input  logic [mnva_pkg::DSR_W-1:0]  divisor,
  output logic                        done,
  output logic [mnva_pkg::DVD_W-1:0]  quotient
);
  import mnva_pkg::*;

  logic [DSR_W:0]           rem_r, sh, diff;
  logic [DVD_W-1:0]         quo_r;
  logic [DSR_W-1:0]         dsr_r;
  logic [$clog2(DVD_W)-1:0] cnt_r;
  logic                     run_r, done_r, ge;

  always_comb begin
    sh   = {rem_r[DSR_W-1:0], quo_r[DVD_W-1]};
    diff = sh - {1'b0, dsr_r};
    ge   = (sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(DVD_W)'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff : sh;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/mnva_sqrt.sv =====
// Integer square root, one root bit (two radicand bits) per cycle.
module mnva_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mnva_pkg::RAD_W-1:0]   radicand,
  output logic                         done,
  output logic [mnva_pkg::ROOT_W-1:0]  root
);
  import mnva_pkg::*;

  logic [ROOT_W+2:0]         rem_r, rs, trial;
  logic [RAD_W-1:0]          rad_r;
  logic [ROOT_W-1:0]         root_r;
  logic [$clog2(ROOT_W)-1:0] cnt_r;
  logic                      run_r, done_r, ge;

  always_comb begin
    rs    = {rem_r[ROOT_W:0], rad_r[RAD_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = (rs >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(ROOT_W)'(ROOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      rad_r  <= radicand;
      root_r <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? (rs - trial) : rs;
      root_r <= {root_r[ROOT_W-2:0], ge};
      rad_r  <= rad_r << 2;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/mesh_vertex_normal_averager.sv =====
// Top level of the mesh vertex normal averager: sequencer, vertex stores and datapath.
//
// Usage: drive an item on the in_ ports with start high; it is taken at a rising
// edge where busy is low. Operation write stores a vertex position, clears its
// normal sum and face count, and completes in the accepting cycle (busy stays low,
// no result). Operation add face reads three corner positions, forms the cross
// product with a bit-serial multiplier (six products), normalizes it one bit per
// cycle, squares it (three products), takes the square root and three divisions,
// then adds the face normal to the sum of every corner whose face count is below
// 255; when the cross product is zero the normal is zero and the square, root and
// divisions are skipped. Operation read divides the three sums by the face count,
// or gives zeros for a vertex with no faces. Operation three is dropped. The
// multiplier, root and divider units are shared and set the rate; one item runs
// at a time. Each result shows on the out_ ports for one cycle with out_valid
// high; the receiver cannot stall it. After reset the block clears all sums and
// counts, one vertex per cycle, with busy high.
module mesh_vertex_normal_averager (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mnva_pkg::OP_W-1:0]           in_operation,
  input  logic [mnva_pkg::VI_W-1:0]           in_vertex_index,
  input  logic signed [mnva_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [mnva_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [mnva_pkg::POS_W-1:0]   in_pos_z,
  input  logic [mnva_pkg::VI_W-1:0]           in_corner_a,
  input  logic [mnva_pkg::VI_W-1:0]           in_corner_b,
  input  logic [mnva_pkg::VI_W-1:0]           in_corner_c,
  input  logic [mnva_pkg::VI_W-1:0]           in_corner_d,
  input  logic [mnva_pkg::CC_W-1:0]           in_corner_count,
  output logic                                out_valid,
  output logic                                out_result_kind,
  output logic signed [mnva_pkg::NRM_W-1:0]   out_normal_x,
  output logic signed [mnva_pkg::NRM_W-1:0]   out_normal_y,
  output logic signed [mnva_pkg::NRM_W-1:0]   out_normal_z,
  output logic [mnva_pkg::CNT_W-1:0]          out_shared_faces
);
  import mnva_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  logic [POS_W-1:0] pos_x_mem [MAX_VERTICES];
  logic [POS_W-1:0] pos_y_mem [MAX_VERTICES];
  logic [POS_W-1:0] pos_z_mem [MAX_VERTICES];
  logic [SUM_W-1:0] sum_x_mem [MAX_VERTICES];
  logic [SUM_W-1:0] sum_y_mem [MAX_VERTICES];
  logic [SUM_W-1:0] sum_z_mem [MAX_VERTICES];
  logic [CNT_W-1:0] cnt_mem   [MAX_VERTICES];

  logic [POS_W-1:0] pos_rd [3];
  logic [SUM_W-1:0] sum_rd [3];
  logic [CNT_W-1:0] cnt_rd;

  logic [VI_W-1:0]  rd_addr, wr_addr;
  logic             pos_we, sum_we;
  logic [SUM_W-1:0] sum_wd [3];
  logic [CNT_W-1:0] cnt_wd;

  logic [VI_W-1:0]  clr_r;
  logic             accept;
  logic [OP_W-1:0]  op_r;
  logic [VI_W-1:0]  vi_r;
  logic [VI_W-1:0]  cor_r [4];
  logic [CC_W-1:0]  ncor_r, ncor_in;
  logic [2:0]       step_r;
  logic [1:0]       acc_i_r;

  logic [POS_W-1:0]  p0_r [3];
  logic [POS_W-1:0]  p1_r [3];
  logic [EMAG_W-1:0] emag_r [6];
  logic              eneg_r [6];
  logic [PROD_W-1:0] prod_r [6];
  logic              pneg_r [6];
  logic [CM_W-1:0]   cm_r [3];
  logic              cneg_r [3];
  logic [RAD_W-1:0]  sq_r;
  logic [ROOT_W-1:0] len_r;
  logic [NRM_W-1:0]  n_r [3];
  logic [SUM_W-1:0]  avg_mag_r [3];
  logic              avg_neg_r [3];
  logic [CNT_W-1:0]  avg_cnt_r;

  logic              out_valid_r, out_kind_r;
  logic [NRM_W-1:0]  out_n_r [3];
  logic [CNT_W-1:0]  out_cnt_r;

  logic signed [POS_W:0] ed [6];
  logic [POS_W:0]        emg [6];
  logic [1:0]            esh;
  logic [CM_W-1:0]       cm_new [3];
  logic                  cneg_new [3];
  logic signed [CM_W-1:0] sp [6];
  logic signed [CM_W-1:0] cdif [3];
  logic                  cm_zero, cm_hi, cm_lo;

  logic              mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DSR_W-1:0]  div_dsr;
  logic [ROOT_W-1:0] sqrt_root;
  logic [NRM_W-1:0]  qv;
  logic              qneg;

  logic [VI_W-1:0]  acc_v;
  logic             acc_ok;
  logic [SUM_W:0]   sat_t [3];
  logic             acc_last;

  mnva_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  mnva_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sq_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  mnva_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    if (in_corner_count < CC_W'(3)) begin
      ncor_in = CC_W'(3);
    end else if (in_corner_count > CC_W'(CORNER_LIM)) begin
      ncor_in = CC_W'(CORNER_LIM);
    end else begin
      ncor_in = in_corner_count;
    end
  end

  // edge vectors and their common pre-shift
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ed[k]   = $signed({p1_r[k][POS_W-1], p1_r[k]}) - $signed({p0_r[k][POS_W-1], p0_r[k]});
      ed[k+3] = $signed({pos_rd[k][POS_W-1], pos_rd[k]})
                - $signed({p0_r[k][POS_W-1], p0_r[k]});
    end
    for (int i = 0; i < 6; i++) begin
      emg[i] = ed[i][POS_W] ? (POS_W+1)'(-ed[i]) : (POS_W+1)'(ed[i]);
    end
    if (emg[0][32] | emg[1][32] | emg[2][32] | emg[3][32] | emg[4][32] | emg[5][32]) begin
      esh = 2'd3;
    end else if (emg[0][31] | emg[1][31] | emg[2][31] | emg[3][31] | emg[4][31]
                 | emg[5][31]) begin
      esh = 2'd2;
    end else if (emg[0][30] | emg[1][30] | emg[2][30] | emg[3][30] | emg[4][30]
                 | emg[5][30]) begin
      esh = 2'd1;
    end else begin
      esh = 2'd0;
    end
  end

  // cross product from signed partial products
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sp[i] = pneg_r[i] ? -$signed({2'b00, prod_r[i]}) : $signed({2'b00, prod_r[i]});
    end
    cdif[0] = sp[0] - sp[1];
    cdif[1] = sp[2] - sp[3];
    cdif[2] = sp[4] - sp[5];
    for (int k = 0; k < 3; k++) begin
      cneg_new[k] = cdif[k][CM_W-1];
      cm_new[k]   = cneg_new[k] ? CM_W'(-cdif[k]) : CM_W'(cdif[k]);
    end
    cm_zero = (cm_r[0] == '0) && (cm_r[1] == '0) && (cm_r[2] == '0);
    cm_hi   = (|cm_r[0][CM_W-1:31]) | (|cm_r[1][CM_W-1:31]) | (|cm_r[2][CM_W-1:31]);
    cm_lo   = !((|cm_r[0][CM_W-1:30]) | (|cm_r[1][CM_W-1:30]) | (|cm_r[2][CM_W-1:30]));
  end

  // accumulate into one corner
  always_comb begin
    acc_v    = cor_r[acc_i_r];
    acc_ok   = ({1'b0, acc_v} < (VI_W+1)'(MAX_VERTICES)) && (cnt_rd < CNT_W'(MAX_SHARED));
    acc_last = ({1'b0, acc_i_r} == (ncor_r - 1'b1));
    for (int k = 0; k < 3; k++) begin
      sat_t[k] = {sum_rd[k][SUM_W-1], sum_rd[k]}
                 + {{(SUM_W+1-NRM_W){n_r[k][NRM_W-1]}}, n_r[k]};
    end
  end

  always_comb begin
    qneg = (op_r == OP_FACE) ? cneg_r[step_r[1:0]] : avg_neg_r[step_r[1:0]];
    qv   = qneg ? -div_q[NRM_W-1:0] : div_q[NRM_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == VI_W'(MAX_VERTICES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_FACE: state_nxt = ST_RDA;
            OP_READ: state_nxt = ST_VR_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RDA:     state_nxt = ST_RDB;
      ST_RDB:     state_nxt = ST_RDC;
      ST_RDC:     state_nxt = ST_EDGE;
      ST_EDGE:    state_nxt = ST_MUL_GO;
      ST_MUL_GO:  state_nxt = ST_MUL_WT;
      ST_MUL_WT: begin
        if (mul_done) state_nxt = (step_r == 3'd5) ? ST_CROSS : ST_MUL_GO;
      end
      ST_CROSS:   state_nxt = ST_NORM;
      ST_NORM: begin
        if (cm_zero) state_nxt = ST_ACC_RD;
        else if (!cm_hi && !cm_lo) state_nxt = ST_SQ_GO;
      end
      ST_SQ_GO:   state_nxt = ST_SQ_WT;
      ST_SQ_WT: begin
        if (mul_done) state_nxt = (step_r == 3'd2) ? ST_SQRT_GO : ST_SQ_GO;
      end
      ST_SQRT_GO: state_nxt = ST_SQRT_WT;
      ST_SQRT_WT: begin
        if (sqrt_done) state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO:  state_nxt = ST_DIV_WT;
      ST_DIV_WT: begin
        if (div_done) begin
          if (step_r != 3'd2) state_nxt = ST_DIV_GO;
          else if (op_r == OP_FACE) state_nxt = ST_ACC_RD;
          else state_nxt = ST_OUT;
        end
      end
      ST_ACC_RD:  state_nxt = ST_ACC_WR;
      ST_ACC_WR:  state_nxt = acc_last ? ST_OUT : ST_ACC_RD;
      ST_VR_RD:   state_nxt = ST_VR_CHK;
      ST_VR_CHK:  state_nxt = (cnt_rd == '0) ? ST_OUT : ST_DIV_GO;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_addr    = vi_r;
    wr_addr    = clr_r;
    pos_we     = 1'b0;
    sum_we     = 1'b0;
    cnt_wd     = '0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = {2'b00, emag_r[pair_a(step_r)]};
    mul_b      = {2'b00, emag_r[pair_b(step_r)]};
    for (int k = 0; k < 3; k++) sum_wd[k] = '0;
    if (op_r == OP_FACE) begin
      div_dvd = {3'b000, cm_r[step_r[1:0]][30:0], {FRAC_W{1'b0}}};
      div_dsr = len_r;
    end else begin
      div_dvd = {{(DVD_W-SUM_W){1'b0}}, avg_mag_r[step_r[1:0]]};
      div_dsr = {{(DSR_W-CNT_W){1'b0}}, avg_cnt_r};
    end
    case (state_r)
      ST_CLEAR: sum_we = 1'b1;
      ST_IDLE: begin
        wr_addr = in_vertex_index;
        if (start && (in_operation == OP_WRITE)
            && ({1'b0, in_vertex_index} < (VI_W+1)'(MAX_VERTICES))) begin
          pos_we = 1'b1;
          sum_we = 1'b1;
        end
      end
      ST_RDA:   rd_addr = cor_r[0];
      ST_RDB:   rd_addr = cor_r[1];
      ST_RDC:   rd_addr = cor_r[2];
      ST_MUL_GO: mul_start = 1'b1;
      ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = cm_r[step_r[1:0]][MUL_W-1:0];
        mul_b     = cm_r[step_r[1:0]][MUL_W-1:0];
      end
      ST_SQRT_GO: sqrt_start = 1'b1;
      ST_DIV_GO:  div_start  = 1'b1;
      ST_ACC_RD:  rd_addr = acc_v;
      ST_ACC_WR: begin
        wr_addr = acc_v;
        sum_we  = acc_ok;
        cnt_wd  = cnt_rd + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (!sat_t[k][SUM_W] && sat_t[k][SUM_W-1]) begin
            sum_wd[k] = {1'b0, {(SUM_W-1){1'b1}}};
          end else if (sat_t[k][SUM_W] && !sat_t[k][SUM_W-1]) begin
            sum_wd[k] = {1'b1, {(SUM_W-1){1'b0}}};
          end else begin
            sum_wd[k] = sat_t[k][SUM_W-1:0];
          end
        end
      end
      default: rd_addr = vi_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_x_mem[wr_addr] <= in_pos_x;
      pos_y_mem[wr_addr] <= in_pos_y;
      pos_z_mem[wr_addr] <= in_pos_z;
    end
    pos_rd[0] <= pos_x_mem[rd_addr];
    pos_rd[1] <= pos_y_mem[rd_addr];
    pos_rd[2] <= pos_z_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_x_mem[wr_addr] <= sum_wd[0];
      sum_y_mem[wr_addr] <= sum_wd[1];
      sum_z_mem[wr_addr] <= sum_wd[2];
      cnt_mem[wr_addr]   <= cnt_wd;
    end
    sum_rd[0] <= sum_x_mem[rd_addr];
    sum_rd[1] <= sum_y_mem[rd_addr];
    sum_rd[2] <= sum_z_mem[rd_addr];
    cnt_rd    <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      acc_i_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      case (state_r)
        ST_IDLE:   step_r <= '0;
        ST_CROSS:  step_r <= '0;
        ST_VR_CHK: step_r <= '0;
        ST_MUL_WT: begin
          if (mul_done) step_r <= (step_r == 3'd5) ? 3'd0 : step_r + 1'b1;
        end
        ST_SQ_WT: begin
          if (mul_done) step_r <= (step_r == 3'd2) ? 3'd0 : step_r + 1'b1;
        end
        ST_DIV_WT: begin
          if (div_done && (step_r != 3'd2)) step_r <= step_r + 1'b1;
        end
        default: step_r <= step_r;
      endcase
      if (state_r == ST_ACC_WR) acc_i_r <= acc_i_r + 1'b1;
      else if (state_r == ST_IDLE) acc_i_r <= '0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      vi_r     <= in_vertex_index;
      cor_r[0] <= in_corner_a;
      cor_r[1] <= in_corner_b;
      cor_r[2] <= in_corner_c;
      cor_r[3] <= in_corner_d;
      ncor_r   <= ncor_in;
    end
    case (state_r)
      ST_RDB: p0_r <= pos_rd;
      ST_RDC: p1_r <= pos_rd;
      ST_EDGE: begin
        for (int i = 0; i < 6; i++) begin
          eneg_r[i] <= ed[i][POS_W];
          emag_r[i] <= EMAG_W'(emg[i] >> esh);
        end
      end
      ST_MUL_WT: begin
        if (mul_done) begin
          prod_r[step_r] <= mul_p[PROD_W-1:0];
          pneg_r[step_r] <= eneg_r[pair_a(step_r)] ^ eneg_r[pair_b(step_r)];
        end
      end
      ST_CROSS: begin
        cm_r   <= cm_new;
        cneg_r <= cneg_new;
        sq_r   <= '0;
      end
      ST_NORM: begin
        if (cm_zero) begin
          for (int k = 0; k < 3; k++) n_r[k] <= '0;
        end else if (cm_hi) begin
          for (int k = 0; k < 3; k++) cm_r[k] <= cm_r[k] >> 1;
        end else if (cm_lo) begin
          for (int k = 0; k < 3; k++) cm_r[k] <= cm_r[k] << 1;
        end
      end
      ST_SQ_WT: begin
        if (mul_done) sq_r <= sq_r + mul_p;
      end
      ST_SQRT_WT: begin
        if (sqrt_done) len_r <= sqrt_root;
      end
      ST_DIV_WT: begin
        if (div_done) n_r[step_r[1:0]] <= qv;
      end
      ST_VR_CHK: begin
        avg_cnt_r <= cnt_rd;
        for (int k = 0; k < 3; k++) begin
          avg_neg_r[k] <= sum_rd[k][SUM_W-1];
          avg_mag_r[k] <= sum_rd[k][SUM_W-1] ? -sum_rd[k] : sum_rd[k];
          if (cnt_rd == '0) n_r[k] <= '0;
        end
      end
      ST_OUT: begin
        out_kind_r <= (op_r == OP_FACE) ? KIND_FACE : KIND_VERTEX;
        out_n_r    <= n_r;
        out_cnt_r  <= (op_r == OP_FACE) ? '0 : avg_cnt_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_normal_x     = out_n_r[0];
  assign out_normal_y     = out_n_r[1];
  assign out_normal_z     = out_n_r[2];
  assign out_shared_faces = out_cnt_r;

  `ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `ASSERT_NEVER(a_no_result_in_clear, (state_r == ST_CLEAR) && out_valid_r)
  `ASSERT_NEVER(a_pos_we_only_idle, pos_we && (state_r != ST_IDLE))

endmodule

// ===== sim/mesh_vertex_normal_averager_test.sv =====
// Testbench for the mesh vertex normal averager: directed and random items checked by a predictor.
module mesh_vertex_normal_averager_test;
  import mnva_pkg::*;

  typedef struct {
    op_t                     operation;
    logic [VI_W-1:0]         vertex_index;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [VI_W-1:0]         corner_a, corner_b, corner_c, corner_d;
    logic [CC_W-1:0]         corner_count;
  } mesh_item_t;

  typedef struct {
    logic                    kind;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic [CNT_W-1:0]        shared;
  } normal_result_t;

  class normal_ledger;
    int                      pos_x[MAX_VERTICES], pos_y[MAX_VERTICES], pos_z[MAX_VERTICES];
    longint                  acc_x[MAX_VERTICES], acc_y[MAX_VERTICES], acc_z[MAX_VERTICES];
    int                      faces[MAX_VERTICES];
    normal_result_t          pending_normals[$];
    int                      mismatches;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint sum_clamp(input longint s, input longint d);
      longint t;
      t = s + d;
      if (t > 64'sd549755813887) t = 64'sd549755813887;
      if (t < -64'sd549755813888) t = -64'sd549755813888;
      return t;
    endfunction

    function automatic void face_unit_normal(input logic [VI_W-1:0] ia, ib, ic,
                                             output longint n[3]);
      longint          p[3][3];
      longint          e[6];
      longint          c[3];
      bit              ng[6];
      bit              cn[3];
      longint unsigned m[6];
      longint unsigned cm[3];
      longint unsigned mx, sq, ln;
      int              s;
      p[0][0] = pos_x[ia]; p[0][1] = pos_y[ia]; p[0][2] = pos_z[ia];
      p[1][0] = pos_x[ib]; p[1][1] = pos_y[ib]; p[1][2] = pos_z[ib];
      p[2][0] = pos_x[ic]; p[2][1] = pos_y[ic]; p[2][2] = pos_z[ic];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        e[k] = p[1][k] - p[0][k];
        e[3+k] = p[2][k] - p[0][k];
      end
      for (int i = 0; i < 6; i++) begin
        ng[i] = e[i] < 0;
        m[i] = ng[i] ? -e[i] : e[i];
        if (m[i] > mx) mx = m[i];
      end
      s = 0;
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 6; i++)
        e[i] = ng[i] ? -longint'(m[i] >> s) : longint'(m[i] >> s);
      c[0] = e[1] * e[5] - e[2] * e[4];
      c[1] = e[2] * e[3] - e[0] * e[5];
      c[2] = e[0] * e[4] - e[1] * e[3];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        cn[k] = c[k] < 0;
        cm[k] = cn[k] ? -c[k] : c[k];
        if (cm[k] > mx) mx = cm[k];
      end
      if (mx == 0) begin
        n[0] = 0; n[1] = 0; n[2] = 0;
        return;
      end
      while (mx >= (64'd1 << 31)) begin
        mx = mx >> 1;
        for (int k = 0; k < 3; k++) cm[k] = cm[k] >> 1;
      end
      while (mx < (64'd1 << 30)) begin
        mx = mx << 1;
        for (int k = 0; k < 3; k++) cm[k] = cm[k] << 1;
      end
      sq = cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2];
      ln = int_sqrt(sq);
      for (int k = 0; k < 3; k++) begin
        n[k] = longint'((cm[k] << 30) / ln);
        if (cn[k]) n[k] = -n[k];
      end
    endfunction

    function automatic logic signed [NRM_W-1:0] vertex_mean(input longint s, input int cnt);
      longint unsigned q;
      q = (s < 0 ? -s : s) / cnt;
      return s < 0 ? -q[31:0] : q[31:0];
    endfunction

    function void note_item(input mesh_item_t it);
      normal_result_t r;
      longint         n[3];
      int             cc;
      logic [VI_W-1:0] v;
      logic [VI_W-1:0] cl[4];
      case (it.operation)
        OP_WRITE: begin
          v = it.vertex_index;
          pos_x[v] = it.pos_x; pos_y[v] = it.pos_y; pos_z[v] = it.pos_z;
          acc_x[v] = 0; acc_y[v] = 0; acc_z[v] = 0;
          faces[v] = 0;
        end
        OP_FACE: begin
          cl[0] = it.corner_a; cl[1] = it.corner_b; cl[2] = it.corner_c; cl[3] = it.corner_d;
          cc = it.corner_count;
          if (cc < 3) cc = 3;
          if (cc > CORNER_LIM) cc = CORNER_LIM;
          face_unit_normal(cl[0], cl[1], cl[2], n);
          for (int i = 0; i < cc; i++) begin
            v = cl[i];
            if (faces[v] < MAX_SHARED) begin
              acc_x[v] = sum_clamp(acc_x[v], n[0]);
              acc_y[v] = sum_clamp(acc_y[v], n[1]);
              acc_z[v] = sum_clamp(acc_z[v], n[2]);
              faces[v]++;
            end
          end
          r.kind = KIND_FACE;
          r.nx = n[0][31:0]; r.ny = n[1][31:0]; r.nz = n[2][31:0];
          r.shared = '0;
          pending_normals.push_back(r);
        end
        OP_READ: begin
          v = it.vertex_index;
          r.kind = KIND_VERTEX;
          if (faces[v] == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.shared = '0;
          end else begin
            r.nx = vertex_mean(acc_x[v], faces[v]);
            r.ny = vertex_mean(acc_y[v], faces[v]);
            r.nz = vertex_mean(acc_z[v], faces[v]);
            r.shared = faces[v][7:0];
          end
          pending_normals.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input normal_result_t got);
      normal_result_t w;
      if (pending_normals.size() == 0) begin
        $error("unexpected result kind %0d", got.kind);
        mismatches++;
        return;
      end
      w = pending_normals.pop_front();
      if (got.kind !== w.kind) begin
        $error("result_kind expected %0d got %0d", w.kind, got.kind); mismatches++;
      end
      if (got.nx !== w.nx) begin
        $error("normal_x expected %0d got %0d", w.nx, got.nx); mismatches++;
      end
      if (got.ny !== w.ny) begin
        $error("normal_y expected %0d got %0d", w.ny, got.ny); mismatches++;
      end
      if (got.nz !== w.nz) begin
        $error("normal_z expected %0d got %0d", w.nz, got.nz); mismatches++;
      end
      if (got.shared !== w.shared) begin
        $error("shared_faces expected %0d got %0d", w.shared, got.shared); mismatches++;
      end
    endfunction
  endclass

  logic                    clk, rst_n, start, busy;
  logic [OP_W-1:0]         in_operation;
  logic [VI_W-1:0]         in_vertex_index, in_corner_a, in_corner_b, in_corner_c, in_corner_d;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic [CC_W-1:0]         in_corner_count;
  logic                    out_valid, out_result_kind;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [CNT_W-1:0]        out_shared_faces;

  normal_ledger    ledger = new();
  int              taken_items;
  int              idle_pct;
  logic [VI_W-1:0] written_verts[$];
  bit              is_written[MAX_VERTICES];

  mesh_vertex_normal_averager u_top (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_vertex_index, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_corner_a, .in_corner_b, .in_corner_c, .in_corner_d, .in_corner_count,
    .out_valid, .out_result_kind, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_shared_faces
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    mesh_item_t     it;
    normal_result_t r;
    if (rst_n) begin
      if (out_valid) begin
        r.kind = out_result_kind;
        r.nx = out_normal_x; r.ny = out_normal_y; r.nz = out_normal_z;
        r.shared = out_shared_faces;
        ledger.check_result(r);
      end
      if (start && !busy) begin
        it.operation = op_t'(in_operation);
        it.vertex_index = in_vertex_index;
        it.pos_x = in_pos_x; it.pos_y = in_pos_y; it.pos_z = in_pos_z;
        it.corner_a = in_corner_a; it.corner_b = in_corner_b;
        it.corner_c = in_corner_c; it.corner_d = in_corner_d;
        it.corner_count = in_corner_count;
        ledger.note_item(it);
        taken_items++;
      end
    end
  end

  function automatic mesh_item_t blank_item();
    mesh_item_t it;
    it.operation = OP_NONE;
    it.vertex_index = $urandom;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.corner_a = $urandom; it.corner_b = $urandom;
    it.corner_c = $urandom; it.corner_d = $urandom;
    it.corner_count = $urandom;
    return it;
  endfunction

  function automatic mesh_item_t write_item(input logic [VI_W-1:0] v,
                                            input logic signed [POS_W-1:0] x, y, z);
    mesh_item_t it;
    it = blank_item();
    it.operation = OP_WRITE;
    it.vertex_index = v;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    return it;
  endfunction

  function automatic mesh_item_t face_item(input logic [VI_W-1:0] a, b, c, d,
                                           input logic [CC_W-1:0] cc);
    mesh_item_t it;
    it = blank_item();
    it.operation = OP_FACE;
    it.corner_a = a; it.corner_b = b; it.corner_c = c; it.corner_d = d;
    it.corner_count = cc;
    return it;
  endfunction

  function automatic mesh_item_t read_item(input logic [VI_W-1:0] v);
    mesh_item_t it;
    it = blank_item();
    it.operation = OP_READ;
    it.vertex_index = v;
    return it;
  endfunction

  task automatic send_item(input mesh_item_t it);
    int n0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    if (it.operation == OP_WRITE && !is_written[it.vertex_index]) begin
      is_written[it.vertex_index] = 1'b1;
      written_verts.push_back(it.vertex_index);
    end
    start <= 1'b1;
    in_operation <= it.operation;
    in_vertex_index <= it.vertex_index;
    in_pos_x <= it.pos_x; in_pos_y <= it.pos_y; in_pos_z <= it.pos_z;
    in_corner_a <= it.corner_a; in_corner_b <= it.corner_b;
    in_corner_c <= it.corner_c; in_corner_d <= it.corner_d;
    in_corner_count <= it.corner_count;
    n0 = taken_items;
    do @(negedge clk); while (taken_items == n0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (ledger.pending_normals.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2:    return $urandom;
      default: return $signed($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic logic [VI_W-1:0] pick_written();
    return written_verts[$urandom_range(written_verts.size() - 1)];
  endfunction

  function automatic mesh_item_t random_item();
    logic [VI_W-1:0] a, b, c;
    int              sel;
    sel = $urandom_range(99);
    if (sel < 30) begin
      return write_item($urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(31),
                        rand_coord(), rand_coord(), rand_coord());
    end else if (sel < 68) begin
      a = pick_written(); b = pick_written(); c = pick_written();
      if ($urandom_range(15) == 0) b = a;
      return face_item(a, b, c, $urandom_range(3) == 0 ? $urandom : pick_written(),
                       $urandom_range(5) == 0 ? $urandom : $urandom_range(4, 3));
    end else if (sel < 96) begin
      return read_item($urandom_range(7) == 0 ? $urandom_range(1023) : pick_written());
    end
    return blank_item();
  endfunction

  initial begin
    int phase_pct[4];
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_NONE;
    in_vertex_index = '0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_corner_a = '0; in_corner_b = '0; in_corner_c = '0; in_corner_d = '0;
    in_corner_count = 3'd3;
    taken_items = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(write_item(10'd0, 32'sh0, 32'sh0, 32'sh0));
    send_item(write_item(10'd1, 32'sh7fffffff, 32'sh80000000, 32'sh0));
    send_item(write_item(10'd2, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_item(write_item(10'd3, 32'sh10000, 32'sh20000, -32'sh30000));
    send_item(write_item(10'd1023, 32'shffffffff, 32'sh1, 32'sh80000000));
    send_item(write_item(10'd5, 32'sh1234, -32'sh5678, 32'sh9abc));
    send_item(face_item(10'd0, 10'd1, 10'd2, 10'd3, 3'd3));
    send_item(face_item(10'd0, 10'd3, 10'd1023, 10'd2, 3'd4));
    send_item(face_item(10'd1023, 10'd2, 10'd1, 10'd0, 3'd0));
    send_item(face_item(10'd3, 10'd0, 10'd1, 10'd1023, 3'd7));
    send_item(face_item(10'd2, 10'd2, 10'd3, 10'd2, 3'd4));
    send_item(face_item(10'd5, 10'd5, 10'd5, 10'd5, 3'd2));
    send_item(read_item(10'd0));
    send_item(read_item(10'd2));
    send_item(read_item(10'd1023));
    send_item(read_item(10'd700));
    send_item(blank_item());
    for (int i = 0; i < 64; i++)
      send_item(face_item(10'd5, 10'd5, 10'd5, 10'd5, 3'd4));
    send_item(read_item(10'd5));
    send_item(write_item(10'd5, 32'sh0, 32'sh1, 32'sh2));
    send_item(read_item(10'd5));
    drain_results();

    for (int i = 6; i < 24; i++)
      send_item(write_item(i[VI_W-1:0], rand_coord(), rand_coord(), rand_coord()));

    phase_pct[0] = 0; phase_pct[1] = 87; phase_pct[2] = 0; phase_pct[3] = 31;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      for (int i = 0; i < 440; i++) send_item(random_item());
      drain_results();
    end

    repeat (700) @(negedge clk);
    if (ledger.mismatches == 0 && ledger.pending_normals.size() == 0) begin
      $display("[mesh_vertex_normal_averager] OK");
    end else begin
      if (ledger.pending_normals.size() != 0)
        $error("%0d results never arrived", ledger.pending_normals.size());
      $display("[mesh_vertex_normal_averager] ERROR");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("[mesh_vertex_normal_averager] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mnva_pkg.sv
rtl/core/mnva_mul.sv
rtl/core/mnva_div.sv
rtl/core/mnva_sqrt.sv
rtl/core/mesh_vertex_normal_averager.sv
sim/mesh_vertex_normal_averager_test.sv
